// ===== rtl/brre_pkg.sv =====
// ----------------------------------------------------------------------------
// brre_pkg
// Shared types and constants of the binary row run extractor: field widths,
// register indexes and reset values, pixel colour codes and record kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package brre_pkg;

   localparam int ROW_WIDTH_W = 13;
   localparam int SCALE_W     = 10;
   localparam int OFFSET_W    = 24;
   localparam int ID_W        = 24;
   localparam int COORD_W     = 25;
   localparam int LEN_W       = 22;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;

   localparam logic [ROW_WIDTH_W-1:0]     ROW_WIDTH_RESET = 13'd1;
   localparam logic [SCALE_W-1:0]         SCALE_RESET     = 10'd1;
   localparam logic signed [OFFSET_W-1:0] X_OFFSET_RESET  = 24'sd5348;
   localparam logic signed [OFFSET_W-1:0] Y_OFFSET_RESET  = 24'sd50;

   typedef enum logic [1:0] {
      REG_ROW_WIDTH = 2'd0,
      REG_SCALE     = 2'd1,
      REG_X_OFFSET  = 2'd2,
      REG_Y_OFFSET  = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      COLOUR_CLEAR = 2'd0,
      COLOUR_SET   = 2'd1,
      COLOUR_NONE  = 2'd2
   } colour_type;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_END   = 1'b1
   } kind_type;

   // records that one pixel produces, start record always goes first
   typedef struct packed {
      logic has_start;
      logic has_end;
   } rec_flags_type;

endpackage

`default_nettype wire

// ===== rtl/brre_if.sv =====
// ----------------------------------------------------------------------------
// brre_if
// Valid/ready channels of the run extractor: the pixel request channel and
// the run record response channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface brre_req_if;
   import brre_pkg::*;

   logic valid;
   logic ready;
   logic pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface brre_rsp_if;
   import brre_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [ID_W-1:0]           run_id;
   logic signed [COORD_W-1:0] x_coord;
   logic signed [COORD_W-1:0] y_coord;
   logic [LEN_W-1:0]          run_length;
   logic                      last;

   modport source (output valid, output kind, output run_id, output x_coord,
                   output y_coord, output run_length, output last, input ready);
   modport sink   (input valid, input kind, input run_id, input x_coord,
                   input y_coord, input run_length, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/brre_track.sv =====
// ----------------------------------------------------------------------------
// brre_track
// Run tracking front end: keeps column, row, previous colour, run start and
// run counter, and registers the raw records caused by each accepted pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module brre_track #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int COL_W      = 12,
   parameter int ROW_W      = 12
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire [brre_pkg::ROW_WIDTH_W-1:0]   row_width,
   input  wire                               in_valid,
   output logic                              in_ready,
   input  wire                               pixel,
   output logic                              out_valid,
   input  wire                               out_ready,
   output brre_pkg::rec_flags_type           out_flags,
   output logic [brre_pkg::ID_W-1:0]         out_id,
   output logic [COL_W-1:0]                  out_col,
   output logic [ROW_W-1:0]                  out_row,
   output logic [COL_W-1:0]                  out_len_m1
);
   import brre_pkg::*;

   localparam int CMP_W = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;

   colour_type       prev_ff, prev_in;
   logic [COL_W-1:0] start_col_ff, start_col_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ID_W-1:0]  cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   rec_flags_type    flags_ff, flags_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [COL_W-1:0] ocol_ff;
   logic [ROW_W-1:0] orow_ff;
   logic [COL_W-1:0] len_ff, len_in;

   logic [CMP_W-1:0] width_eff;
   logic [CMP_W-1:0] col_next;
   logic             row_end;
   logic             accept;
   logic             run_start;
   logic             end_clear;
   logic             end_row;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      width_eff = CMP_W'(row_width);
      if (row_width == '0) begin
         width_eff = CMP_W'(1);
      end
      if (width_eff > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end
   end

   assign col_next  = CMP_W'(col_ff) + CMP_W'(1);
   assign row_end   = (col_next >= width_eff);
   assign run_start = pixel && (prev_ff != COLOUR_SET);
   assign end_clear = !pixel && (prev_ff == COLOUR_SET);
   assign end_row   = row_end && pixel;

   always_comb begin
      flags_in.has_start = run_start;
      flags_in.has_end   = end_clear || end_row;
      id_in              = run_start ? cnt_ff : cnt_ff - ID_W'(1);
      if (end_clear) begin
         len_in = col_ff - start_col_ff - COL_W'(1);
      end else if (run_start) begin
         len_in = '0;
      end else begin
         len_in = col_ff - start_col_ff;
      end
   end

   always_comb begin
      prev_in      = prev_ff;
      start_col_in = start_col_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff && !out_ready;
      if (accept) begin
         valid_in = flags_in.has_start || flags_in.has_end;
         if (run_start) begin
            cnt_in       = cnt_ff + ID_W'(1);
            start_col_in = col_ff;
         end
         if (row_end) begin
            prev_in = COLOUR_NONE;
            col_in  = '0;
            if (row_ff == ROW_W'(MAX_HEIGHT - 1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            prev_in = pixel ? COLOUR_SET : COLOUR_CLEAR;
            col_in  = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= COLOUR_NONE;
         start_col_ff <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         valid_ff     <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         start_col_ff <= start_col_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         flags_ff <= flags_in;
         id_ff    <= id_in;
         ocol_ff  <= col_ff;
         orow_ff  <= row_ff;
         len_ff   <= len_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_flags  = flags_ff;
   assign out_id     = id_ff;
   assign out_col    = ocol_ff;
   assign out_row    = orow_ff;
   assign out_len_m1 = len_ff;

endmodule

`default_nettype wire

// ===== rtl/brre_scale.sv =====
// ----------------------------------------------------------------------------
// brre_scale
// Coordinate and length scaling: one multiply and one add per field, giving
// the offset start coordinates and the scaled run length.
// ----------------------------------------------------------------------------
`default_nettype none

module brre_scale #(
   parameter int COL_W = 12,
   parameter int ROW_W = 12
) (
   input  wire [COL_W-1:0]                        col,
   input  wire [ROW_W-1:0]                        row,
   input  wire [COL_W-1:0]                        len_m1,
   input  wire [brre_pkg::SCALE_W-1:0]            scale,
   input  wire signed [brre_pkg::OFFSET_W-1:0]    x_offset,
   input  wire signed [brre_pkg::OFFSET_W-1:0]    y_offset,
   output logic signed [brre_pkg::COORD_W-1:0]    x_coord,
   output logic signed [brre_pkg::COORD_W-1:0]    y_coord,
   output logic [brre_pkg::LEN_W-1:0]             run_length
);
   import brre_pkg::*;

   localparam int XP_W = COL_W + SCALE_W;
   localparam int YP_W = ROW_W + SCALE_W;

   logic [XP_W-1:0] x_prod;
   logic [YP_W-1:0] y_prod;
   logic [XP_W-1:0] len_prod;

   assign x_prod   = XP_W'(col) * XP_W'(scale);
   assign y_prod   = YP_W'(row) * YP_W'(scale);
   assign len_prod = XP_W'(len_m1) * XP_W'(scale);

   // sign-extend the offset, then wrap the sum to the coordinate width
   assign x_coord = $signed({x_offset[OFFSET_W-1], x_offset} + COORD_W'(x_prod));
   assign y_coord = $signed({y_offset[OFFSET_W-1], y_offset} + COORD_W'(y_prod));
   assign run_length = LEN_W'(len_prod) + LEN_W'(1);

endmodule

`default_nettype wire

// ===== rtl/brre_emit.sv =====
// ----------------------------------------------------------------------------
// brre_emit
// Output record register: holds the records of one pixel and sends them one
// item at a time, start record first, marking the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module brre_emit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  in_valid,
   output logic                                 in_ready,
   input  brre_pkg::rec_flags_type              in_flags,
   input  wire [brre_pkg::ID_W-1:0]             in_id,
   input  wire signed [brre_pkg::COORD_W-1:0]   in_x,
   input  wire signed [brre_pkg::COORD_W-1:0]   in_y,
   input  wire [brre_pkg::LEN_W-1:0]            in_len,
   output logic                                 out_valid,
   input  wire                                  out_ready,
   output logic                                 out_kind,
   output logic [brre_pkg::ID_W-1:0]            out_run_id,
   output logic signed [brre_pkg::COORD_W-1:0]  out_x,
   output logic signed [brre_pkg::COORD_W-1:0]  out_y,
   output logic [brre_pkg::LEN_W-1:0]           out_len,
   output logic                                 out_last
);
   import brre_pkg::*;

   logic                      pend_start_ff, pend_start_in;
   logic                      pend_end_ff, pend_end_in;
   logic [ID_W-1:0]           id_ff;
   logic signed [COORD_W-1:0] x_ff;
   logic signed [COORD_W-1:0] y_ff;
   logic [LEN_W-1:0]          len_ff;
   logic                      sent;
   logic                      final_beat;
   logic                      load;

   assign out_valid  = pend_start_ff || pend_end_ff;
   assign out_last   = !(pend_start_ff && pend_end_ff);
   assign sent       = out_valid && out_ready;
   assign final_beat = sent && out_last;
   assign in_ready   = !out_valid || final_beat;
   assign load       = in_valid && in_ready;

   always_comb begin
      pend_start_in = pend_start_ff;
      pend_end_in   = pend_end_ff;
      if (sent) begin
         if (pend_start_ff) begin
            pend_start_in = 1'b0;
         end else begin
            pend_end_in = 1'b0;
         end
      end
      if (load) begin
         pend_start_in = in_flags.has_start;
         pend_end_in   = in_flags.has_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_start_ff <= 1'b0;
         pend_end_ff   <= 1'b0;
      end else begin
         pend_start_ff <= pend_start_in;
         pend_end_ff   <= pend_end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         id_ff  <= in_id;
         x_ff   <= in_x;
         y_ff   <= in_y;
         len_ff <= in_len;
      end
   end

   // start records carry coordinates, end records carry the length
   assign out_kind   = pend_start_ff ? KIND_START : KIND_END;
   assign out_run_id = id_ff;
   assign out_x      = pend_start_ff ? x_ff : '0;
   assign out_y      = pend_start_ff ? y_ff : '0;
   assign out_len    = pend_start_ff ? '0 : len_ff;

endmodule

`default_nettype wire

// ===== rtl/binary_row_run_extractor.sv =====
// ----------------------------------------------------------------------------
// binary_row_run_extractor
// A pixel's records are registered in the tracking stage, then in the output
// register. Throughput: one pixel per cycle while the output is not stalled;
// a pixel that both starts and ends a run (single set pixel in the last
// column) sends two records, one per cycle, and can stall the input meanwhile.
// Reset: synchronous; clears counters, run id, colour to "no pixel yet" and
// loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_row_run_extractor #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire [brre_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire [brre_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [brre_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   brre_req_if.sink                          req_ch,
   brre_rsp_if.source                        rsp_ch
);
   import brre_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   // configuration registers
   logic [ROW_WIDTH_W-1:0]     row_width_ff;
   logic [SCALE_W-1:0]         scale_ff;
   logic signed [OFFSET_W-1:0] x_offset_ff;
   logic signed [OFFSET_W-1:0] y_offset_ff;

   logic          csr_write;
   reg_index_type csr_index;

   // tracking stage to output register
   logic             s1_valid;
   logic             s1_ready;
   rec_flags_type    s1_flags;
   logic [ID_W-1:0]  s1_id;
   logic [COL_W-1:0] s1_col;
   logic [ROW_W-1:0] s1_row;
   logic [COL_W-1:0] s1_len_m1;

   logic signed [COORD_W-1:0] sc_x;
   logic signed [COORD_W-1:0] sc_y;
   logic [LEN_W-1:0]          sc_len;

   // ---------------------------------------------------------------------
   // Register port: no wait states, write on the access phase.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         scale_ff     <= SCALE_RESET;
         x_offset_ff  <= X_OFFSET_RESET;
         y_offset_ff  <= Y_OFFSET_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ROW_WIDTH: row_width_ff <= csr_pwdata[ROW_WIDTH_W-1:0];
            REG_SCALE:     scale_ff     <= csr_pwdata[SCALE_W-1:0];
            REG_X_OFFSET:  x_offset_ff  <= $signed(csr_pwdata[OFFSET_W-1:0]);
            REG_Y_OFFSET:  y_offset_ff  <= $signed(csr_pwdata[OFFSET_W-1:0]);
            default:       row_width_ff <= row_width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ROW_WIDTH: csr_prdata = CSR_DATA_W'(row_width_ff);
         REG_SCALE:     csr_prdata = CSR_DATA_W'(scale_ff);
         REG_X_OFFSET:  csr_prdata = CSR_DATA_W'($unsigned(x_offset_ff));
         REG_Y_OFFSET:  csr_prdata = CSR_DATA_W'($unsigned(y_offset_ff));
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Stage 1: update run state on each accepted pixel and register the raw
   // records. Pixels that cause no record do not enter the pipeline.
   // ---------------------------------------------------------------------
   brre_track #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COL_W      (COL_W),
      .ROW_W      (ROW_W)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .row_width  (row_width_ff),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .pixel      (req_ch.pixel),
      .out_valid  (s1_valid),
      .out_ready  (s1_ready),
      .out_flags  (s1_flags),
      .out_id     (s1_id),
      .out_col    (s1_col),
      .out_row    (s1_row),
      .out_len_m1 (s1_len_m1)
   );

   // ---------------------------------------------------------------------
   // Scale coordinates and length between stage 1 and the output register.
   // ---------------------------------------------------------------------
   brre_scale #(
      .COL_W (COL_W),
      .ROW_W (ROW_W)
   ) u_scale (
      .col        (s1_col),
      .row        (s1_row),
      .len_m1     (s1_len_m1),
      .scale      (scale_ff),
      .x_offset   (x_offset_ff),
      .y_offset   (y_offset_ff),
      .x_coord    (sc_x),
      .y_coord    (sc_y),
      .run_length (sc_len)
   );

   // ---------------------------------------------------------------------
   // Stage 2: output register, one record per cycle unless stalled; frees
   // itself on the final record so new records can load in the same cycle.
   // ---------------------------------------------------------------------
   brre_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid),
      .in_ready   (s1_ready),
      .in_flags   (s1_flags),
      .in_id      (s1_id),
      .in_x       (sc_x),
      .in_y       (sc_y),
      .in_len     (sc_len),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_kind   (rsp_ch.kind),
      .out_run_id (rsp_ch.run_id),
      .out_x      (rsp_ch.x_coord),
      .out_y      (rsp_ch.y_coord),
      .out_len    (rsp_ch.run_length),
      .out_last   (rsp_ch.last)
   );

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // a start record that is not last is followed by the end of that run
   a_start_then_end : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && (rsp_ch.kind == KIND_START) && !rsp_ch.last
      |=> rsp_ch.valid && (rsp_ch.kind == KIND_END)
          && (rsp_ch.run_id == $past(rsp_ch.run_id)))
      else $error("start record not followed by its end record");

   // an end record always closes the records of its pixel
   a_end_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.kind == KIND_END) |-> rsp_ch.last)
      else $error("end record without last");

   // pipeline comes out of reset empty and ready for a pixel
   a_reset_empty : assert property (@(posedge clock)
      reset |=> req_ch.ready && !rsp_ch.valid && !s1_valid)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ===== tb/run_record_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_record_checker
// Watches the register, pixel and run record ports of the run extractor.
// Predicts the run records of each accepted pixel, keeps them in order and
// compares every accepted record with the oldest one due, field by field.
// ----------------------------------------------------------------------------
module run_record_checker #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire [brre_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire [brre_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   input  wire                                csr_pready,
   brre_req_if                                req_mon,
   brre_rsp_if                                rsp_mon,
   output int                                 failures,
   output int                                 pending
);
   import brre_pkg::*;

   typedef struct packed {
      kind_type                  kind;
      logic [ID_W-1:0]           run_id;
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
      logic [LEN_W-1:0]          run_length;
      logic                      last;
   } run_record_type;

   run_record_type due_records[$];

   logic [ROW_WIDTH_W-1:0]     row_width_cfg;
   logic [SCALE_W-1:0]         scale_cfg;
   logic signed [OFFSET_W-1:0] x_offset_cfg;
   logic signed [OFFSET_W-1:0] y_offset_cfg;

   colour_type      prev_colour;
   logic [11:0]     run_start_col;
   logic [11:0]     column;
   logic [11:0]     row;
   logic [ID_W-1:0] next_run_id;
   int              mismatch_count = 0;

   function automatic run_record_type end_record(input int run);
      run_record_type rec;
      rec            = '0;
      rec.kind       = KIND_END;
      rec.run_id     = next_run_id - 1'b1;
      rec.run_length = LEN_W'((run - 1) * int'(scale_cfg) + 1);
      return rec;
   endfunction

   // advance the row scan by one pixel and queue the records it produces
   function automatic void extract_runs(input logic pixel);
      int             eff_width;
      logic           row_end;
      int             made;
      run_record_type recs[2];
      eff_width = int'(row_width_cfg);
      if (eff_width == 0) eff_width = 1;
      if (eff_width > MAX_WIDTH) eff_width = MAX_WIDTH;
      row_end = (int'(column) + 1 >= eff_width);
      made    = 0;

      if (pixel && prev_colour != COLOUR_SET) begin
         recs[made]         = '0;
         recs[made].kind    = KIND_START;
         recs[made].run_id  = next_run_id;
         recs[made].x_coord = COORD_W'(int'(x_offset_cfg) + int'(column) * int'(scale_cfg));
         recs[made].y_coord = COORD_W'(int'(y_offset_cfg) + int'(row) * int'(scale_cfg));
         made++;
         next_run_id   = next_run_id + 1'b1;
         run_start_col = column;
      end else if (!pixel && prev_colour == COLOUR_SET) begin
         recs[made] = end_record(int'(column) - int'(run_start_col));
         made++;
      end
      prev_colour = pixel ? COLOUR_SET : COLOUR_CLEAR;

      if (row_end) begin
         if (prev_colour == COLOUR_SET) begin
            recs[made] = end_record(int'(column) + 1 - int'(run_start_col));
            made++;
         end
         column      = '0;
         row         = 12'((int'(row) + 1) % MAX_HEIGHT);
         prev_colour = COLOUR_NONE;
      end else begin
         column = column + 1'b1;
      end

      if (made > 0) recs[made-1].last = 1'b1;
      for (int i = 0; i < made; i++) due_records.push_back(recs[i]);
   endfunction

   always @(posedge clock) begin : watch
      run_record_type want;
      if (reset) begin
         row_width_cfg = ROW_WIDTH_RESET;
         scale_cfg     = SCALE_RESET;
         x_offset_cfg  = X_OFFSET_RESET;
         y_offset_cfg  = Y_OFFSET_RESET;
         prev_colour   = COLOUR_NONE;
         run_start_col = '0;
         column        = '0;
         row           = '0;
         next_run_id   = '0;
         due_records.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_ROW_WIDTH: row_width_cfg = csr_pwdata[ROW_WIDTH_W-1:0];
               REG_SCALE:     scale_cfg     = csr_pwdata[SCALE_W-1:0];
               REG_X_OFFSET:  x_offset_cfg  = csr_pwdata[OFFSET_W-1:0];
               REG_Y_OFFSET:  y_offset_cfg  = csr_pwdata[OFFSET_W-1:0];
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) extract_runs(req_mon.pixel);

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_records.size() == 0) begin
               $error("run record with none due: kind %0d run_id %0d",
                      rsp_mon.kind, rsp_mon.run_id);
               mismatch_count++;
            end else begin
               want = due_records.pop_front();
               if (rsp_mon.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_mon.kind);
                  mismatch_count++;
               end
               if (rsp_mon.run_id !== want.run_id) begin
                  $error("run_id: expected %0d, got %0d", want.run_id, rsp_mon.run_id);
                  mismatch_count++;
               end
               if (rsp_mon.x_coord !== want.x_coord) begin
                  $error("x_coord: expected %0d, got %0d", want.x_coord, rsp_mon.x_coord);
                  mismatch_count++;
               end
               if (rsp_mon.y_coord !== want.y_coord) begin
                  $error("y_coord: expected %0d, got %0d", want.y_coord, rsp_mon.y_coord);
                  mismatch_count++;
               end
               if (rsp_mon.run_length !== want.run_length) begin
                  $error("run_length: expected %0d, got %0d",
                         want.run_length, rsp_mon.run_length);
                  mismatch_count++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_mon.last);
                  mismatch_count++;
               end
            end
         end
      end
      failures <= mismatch_count;
      pending  <= due_records.size();
   end

endmodule

// ===== tb/binary_row_run_extractor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_row_run_extractor_test
// Drives pixels and register writes into the run extractor with random gaps
// on both channels. A directed set of rows covers the special cases, and
// random phases follow.
// The checker beside the block predicts and compares the run records.
// ----------------------------------------------------------------------------
module binary_row_run_extractor_test;
   import brre_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    failures;
   int                    pending;
   bit                    req_steady;
   bit                    rsp_steady;

   brre_req_if req_ch ();
   brre_rsp_if rsp_ch ();

   binary_row_run_extractor dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   run_record_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .failures    (failures),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // setup cycle, then access cycle; the register takes the data at the
   // edge that sees penable with pready. Drop psel before the next write so
   // no signal gets two updates in one step.
   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // write all four registers; fill the unused upper data bits with noise
   task automatic configure(input logic [ROW_WIDTH_W-1:0]     width,
                            input logic [SCALE_W-1:0]         factor,
                            input logic signed [OFFSET_W-1:0] off_x,
                            input logic signed [OFFSET_W-1:0] off_y);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      word[ROW_WIDTH_W-1:0] = width;
      write_reg(REG_ROW_WIDTH, word);
      word = $urandom;
      word[SCALE_W-1:0] = factor;
      write_reg(REG_SCALE, word);
      word = $urandom;
      word[OFFSET_W-1:0] = off_x;
      write_reg(REG_X_OFFSET, word);
      word = $urandom;
      word[OFFSET_W-1:0] = off_y;
      write_reg(REG_Y_OFFSET, word);
   endtask

   // hold valid low for a random gap (none in steady stretches), then offer
   // one pixel and wait for the block to take it. Valid stays high after the
   // handshake so a back-to-back item needs only one update of it.
   task automatic send_pixel(input logic level);
      int gap;
      if ($urandom_range(0, 19) == 0) req_steady = !req_steady;
      gap = req_steady ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel <= level;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // send the low count bits of a pattern, leftmost pixel first
   task automatic send_row(input logic [15:0] bits, input int count);
      for (int i = count - 1; i >= 0; i--) send_pixel(bits[i]);
   endtask

   // drop valid, let the last accepted pixel reach the checker, then wait
   // until every record due has arrived and let the block settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      repeat (4) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [OFFSET_W-1:0] pick_offset();
      case ($urandom_range(0, 3))
         0:       return {1'b1, {(OFFSET_W-1){1'b0}}};
         1:       return {1'b0, {(OFFSET_W-1){1'b1}}};
         default: return OFFSET_W'($urandom);
      endcase
   endfunction

   // record side: stall for a random gap before each record,
   // with stretches of no stalls at all
   initial begin : drive_rsp_ready
      int stall;
      forever begin
         if ($urandom_range(0, 19) == 0) rsp_steady = !rsp_steady;
         stall = rsp_steady ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin : stimulus
      logic [ROW_WIDTH_W-1:0] width;
      logic [SCALE_W-1:0]     factor;
      logic                   level;

      reset        <= 1'b1;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      req_ch.valid <= 1'b0;
      req_ch.pixel <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // register defaults: one pixel per row, so each set pixel is a
      // single-pixel run at the row end with the reset offsets
      send_row(16'b101, 3);
      wait_idle();

      // runs closed by a clear pixel and by the row end, then stop mid-row
      // with a run still open at column 4
      configure(13'd8, 10'd1, '0, '0);
      send_row(16'b1101_0011, 8);
      send_row(16'b00101, 5);
      wait_idle();

      // width lowered below the current column: the next pixel ends the row;
      // scale zero collapses coordinates to the offsets and lengths to one
      configure(13'd3, '0, {1'b1, {(OFFSET_W-1){1'b0}}}, {1'b0, {(OFFSET_W-1){1'b1}}});
      send_row(16'b11011, 5);
      wait_idle();

      // width above the maximum clamps to it; largest scale
      configure('1, '1, {1'b0, {(OFFSET_W-1){1'b1}}}, {1'b1, {(OFFSET_W-1){1'b0}}});
      send_row(16'b1011, 4);
      wait_idle();

      // width zero acts as one: every pixel ends its row
      configure('0, 10'd7, pick_offset(), pick_offset());
      send_row(16'b10, 2);
      wait_idle();

      // random phases: mostly narrow rows so rows end often, runs of random
      // length with the odd noise pixel
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 7))
            0:       width = '0;
            1:       width = $urandom_range(0, 1) ? 13'd4096 : '1;
            default: width = ROW_WIDTH_W'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 3))
            0:       factor = '0;
            1:       factor = '1;
            default: factor = SCALE_W'($urandom);
         endcase
         configure(width, factor, pick_offset(), pick_offset());
         level = 1'($urandom_range(0, 1));
         for (int k = 0; k < 50; k++) begin
            if ($urandom_range(0, 2) == 0) level = ~level;
            if ($urandom_range(0, 9) == 0) send_pixel(1'($urandom_range(0, 1)));
            else send_pixel(level);
         end
         wait_idle();
      end

      if (failures == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin : run_limit
      #6_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
